### hdl/msc_pkg.sv
// msc_pkg: shared types and constants for the moesi snoop coherence core
// line state codes, request opcodes, result layout and snoop unit outputs
// no dependencies; imported by every module of the block
package msc_pkg;

  localparam int CACHE_COUNT_DEF = 3;
  localparam int LINE_COUNT_DEF  = 4;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    LS_I = 3'd0,
    LS_E = 3'd1,
    LS_S = 3'd2,
    LS_M = 3'd3,
    LS_O = 3'd4
  } line_state_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_EVICT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_SELF_RD,
    SQ_SNP_RD,
    SQ_SNP_WR,
    SQ_SELF_WR,
    SQ_DONE
  } seq_state_t;

  // result word, hit in bit 0
  typedef struct packed {
    logic [4:0]  pad;
    logic        writeback;
    logic        memory_read;
    logic        shared_found;
    line_state_t new_state;
    line_state_t old_state;
    logic        dirty_hit;
    logic        hit;
  } res_t;

  // snoop unit response for one other cache
  typedef struct packed {
    line_state_t next_state;
    logic        seen;
    logic        flush;
  } snoop_t;

  function automatic logic is_dirty(input line_state_t s);
    return (s == LS_M) || (s == LS_O);
  endfunction

endpackage

### hdl/moesi_snoop_coherence_core.sv
// moesi_snoop_coherence_core: top level of the moesi snoop coherence tracker
// instantiates msc_ctrl, msc_snoop_unit and msc_store; holds the result register
// depends on msc_pkg
//
// usage
//   in channel (in_tvalid/in_tready/in_tdata) carries one request transaction:
//   op, cache_index and line_index. out channel carries one result transaction
//   per request: hit, dirty_hit, old/new requester state, shared_found,
//   memory_read and writeback.
//   after reset the state memory is swept to invalid, one entry per cycle,
//   CACHE_COUNT * 2**max(1, ceil(log2(LINE_COUNT))) entries (12 at the defaults);
//   in_tready stays low until the sweep is done.
//   a request walks the other caches of its line through one shared snoop
//   unit, each in a memory read step and then an update and write-back step.
//   the core takes no new request until the sequencer has passed its done
//   state; the result is moved into the output register, which drives
//   out_tvalid, as the sequencer leaves that state.
//   a stalled receiver does not block the next request: the result waits in
//   the output register while the core takes and works on the next
//   transaction, which then waits until that register is free.
module moesi_snoop_coherence_core #(
  parameter int CACHE_COUNT = msc_pkg::CACHE_COUNT_DEF,
  parameter int LINE_COUNT  = msc_pkg::LINE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // op[1:0], cache_index[3:2], line_index[5:4], zero [7:6]
  input  logic [msc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hit[0], dirty_hit[1], old_state[4:2], new_state[7:5], shared_found[8],
  // memory_read[9], writeback[10], zero [15:11]
  output logic [msc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import msc_pkg::*;

  localparam int CW    = (CACHE_COUNT > 2) ? $clog2(CACHE_COUNT) : 1;
  localparam int LW    = (LINE_COUNT > 2) ? $clog2(LINE_COUNT) : 1;
  localparam int AW    = CW + LW;
  localparam int DEPTH = CACHE_COUNT * (1 << LW);

  // sequencer to result register
  logic   res_valid;
  logic   res_ready;
  res_t   res;

  // snoop unit
  op_t    snp_op;
  snoop_t snp;

  // state memory
  logic [AW-1:0] mem_rd_addr;
  line_state_t   mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  line_state_t   mem_wr_data;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  msc_ctrl #(
    .CACHE_COUNT (CACHE_COUNT),
    .LINE_COUNT  (LINE_COUNT),
    .CW          (CW),
    .LW          (LW),
    .DEPTH       (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (op_t'(in_tdata[1:0])),
    .in_ci       (in_tdata[3:2]),
    .in_li       (in_tdata[5:4]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .snp_op      (snp_op),
    .snp         (snp),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  msc_snoop_unit u_snoop (
    .op  (snp_op),
    .st  (mem_rd_data),
    .snp (snp)
  );

  msc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

### hdl/msc_store.sv
// msc_store: line state memory, one entry per cache and line slot
// one write port and one registered read port; uses msc_pkg
module msc_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output msc_pkg::line_state_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  msc_pkg::line_state_t wr_data
);
  import msc_pkg::*;

  line_state_t mem_r [DEPTH];
  line_state_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/msc_snoop_unit.sv
// msc_snoop_unit: shared snoop transform applied to one other cache per step
// gives the snooped cache's next state, its valid flag and, on a write or evict, its dirty flag; uses msc_pkg
module msc_snoop_unit (
  input  msc_pkg::op_t         op,
  input  msc_pkg::line_state_t st,
  output msc_pkg::snoop_t      snp
);
  import msc_pkg::*;

  always_comb begin
    snp.next_state = st;
    snp.seen       = 1'b0;
    snp.flush      = 1'b0;
    unique case (op)
      OP_READ: begin
        snp.seen = (st != LS_I);
        // a dirty owner keeps supplying data, no flush
        if (st == LS_E) begin
          snp.next_state = LS_S;
        end else if (st == LS_M) begin
          snp.next_state = LS_O;
        end
      end
      OP_WRITE, OP_EVICT: begin
        snp.seen       = (st != LS_I);
        snp.flush      = is_dirty(st);
        snp.next_state = LS_I;
      end
      default: begin
        snp.next_state = st;
      end
    endcase
  end

endmodule

### hdl/msc_ctrl.sv
// msc_ctrl: sequencer that walks the caches of one line through the snoop unit
// drives the state memory, builds the result; uses msc_pkg
module msc_ctrl #(
  parameter int CACHE_COUNT = msc_pkg::CACHE_COUNT_DEF,
  parameter int LINE_COUNT  = msc_pkg::LINE_COUNT_DEF,
  parameter int CW          = 2,
  parameter int LW          = 2,
  parameter int DEPTH       = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msc_pkg::op_t         in_op,
  input  logic [1:0]           in_ci,
  input  logic [1:0]           in_li,
  output logic                 res_valid,
  input  logic                 res_ready,
  output msc_pkg::res_t        res,
  output msc_pkg::op_t         snp_op,
  input  msc_pkg::snoop_t      snp,
  output logic [CW+LW-1:0]     mem_rd_addr,
  input  msc_pkg::line_state_t mem_rd_data,
  output logic                 mem_wr_en,
  output logic [CW+LW-1:0]     mem_wr_addr,
  output msc_pkg::line_state_t mem_wr_data
);
  import msc_pkg::*;

  localparam int AW = CW + LW;

  seq_state_t  state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [CW-1:0] ci_r, ci_nxt;
  logic [LW-1:0] li_r, li_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  line_state_t s_r, s_nxt;
  logic        shared_r, shared_nxt;
  logic        wb_r, wb_nxt;
  res_t        res_r, res_nxt;

  logic        in_range;
  logic        c_last;
  logic        clr_last;
  logic        need_snoop;
  line_state_t self_new;

  assign in_range = (32'(in_ci) < CACHE_COUNT) && (32'(in_li) < LINE_COUNT);
  assign c_last   = (c_r == CW'(CACHE_COUNT - 1));
  assign clr_last = (clr_r == AW'(DEPTH - 1));

  // snoop needed: read miss, write from a state other than E or M, any evict
  always_comb begin
    unique case (op_r)
      OP_READ:  need_snoop = (mem_rd_data == LS_I);
      OP_WRITE: need_snoop = (mem_rd_data != LS_E) && (mem_rd_data != LS_M);
      OP_EVICT: need_snoop = 1'b1;
      default:  need_snoop = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_r)
      OP_READ:  self_new = (s_r == LS_I) ? (shared_r ? LS_S : LS_E) : s_r;
      OP_WRITE: self_new = LS_M;
      OP_EVICT: self_new = LS_I;
      default:  self_new = s_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_CLEAR: begin
        if (clr_last) state_nxt = SQ_IDLE;
      end
      SQ_IDLE: begin
        if (in_valid) state_nxt = in_range ? SQ_SELF_RD : SQ_DONE;
      end
      SQ_SELF_RD: begin
        state_nxt = need_snoop ? SQ_SNP_RD : SQ_SELF_WR;
      end
      SQ_SNP_RD: begin
        if (c_r == ci_r) begin
          state_nxt = c_last ? SQ_SELF_WR : SQ_SNP_RD;
        end else begin
          state_nxt = SQ_SNP_WR;
        end
      end
      SQ_SNP_WR: begin
        state_nxt = c_last ? SQ_SELF_WR : SQ_SNP_RD;
      end
      SQ_SELF_WR: begin
        state_nxt = SQ_DONE;
      end
      SQ_DONE: begin
        if (res_ready) state_nxt = SQ_IDLE;
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state_r == SQ_IDLE);
    res_valid   = (state_r == SQ_DONE);
    res         = res_r;
    snp_op      = op_r;
    mem_rd_addr = (state_r == SQ_IDLE) ? {CW'(in_ci), LW'(in_li)} : {c_r, li_r};
    mem_wr_en   = 1'b0;
    mem_wr_addr = {ci_r, li_r};
    mem_wr_data = self_new;
    unique case (state_r)
      SQ_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = LS_I;
      end
      SQ_SNP_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = {c_r, li_r};
        mem_wr_data = snp.next_state;
      end
      SQ_SELF_WR: begin
        mem_wr_en = 1'b1;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    op_nxt     = op_r;
    ci_nxt     = ci_r;
    li_nxt     = li_r;
    c_nxt      = c_r;
    clr_nxt    = clr_r;
    s_nxt      = s_r;
    shared_nxt = shared_r;
    wb_nxt     = wb_r;
    res_nxt    = res_r;
    unique case (state_r)
      SQ_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
      end
      SQ_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          ci_nxt     = CW'(in_ci);
          li_nxt     = LW'(in_li);
          c_nxt      = '0;
          shared_nxt = 1'b0;
          wb_nxt     = 1'b0;
          if (!in_range) res_nxt = '0;
        end
      end
      SQ_SELF_RD: begin
        s_nxt = mem_rd_data;
      end
      SQ_SNP_RD: begin
        // requester's own slot is skipped
        if ((c_r == ci_r) && !c_last) c_nxt = c_r + CW'(1);
      end
      SQ_SNP_WR: begin
        shared_nxt = shared_r | snp.seen;
        wb_nxt     = wb_r | snp.flush;
        if (!c_last) c_nxt = c_r + CW'(1);
      end
      SQ_SELF_WR: begin
        res_nxt              = '0;
        res_nxt.hit          = (s_r != LS_I);
        res_nxt.dirty_hit    = is_dirty(s_r);
        res_nxt.old_state    = s_r;
        res_nxt.new_state    = self_new;
        res_nxt.shared_found = shared_r;
        res_nxt.memory_read  = (op_r == OP_READ) && (s_r == LS_I) && !shared_r;
        res_nxt.writeback    = wb_r | ((op_r == OP_EVICT) && is_dirty(s_r));
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    op_r     <= op_nxt;
    ci_r     <= ci_nxt;
    li_r     <= li_nxt;
    c_r      <= c_nxt;
    s_r      <= s_nxt;
    shared_r <= shared_nxt;
    wb_r     <= wb_nxt;
    res_r    <= res_nxt;
  end

endmodule

### hdl/msc_checker.sv
// msc_checker: port level checks for moesi_snoop_coherence_core
// bound to the top level below; depends on msc_pkg for data widths
module msc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [msc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [msc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import msc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a taken request leaves the core busy, with in_tready low
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("core ready right after taking a request");

  // hit follows the old state
  a_hit_old: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:2] != 3'd0)))
    else $error("hit disagrees with old state");

  // memory read only on a lone read miss, which ends in E
  a_memrd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |->
      (out_tdata[4:2] == 3'd0) && (out_tdata[7:5] == 3'd1) && !out_tdata[8])
    else $error("memory read outside a lone read miss");

endmodule

bind moesi_snoop_coherence_core msc_checker u_msc_checker (.*);
